/* rtl/core/fqd_pkg.sv */
// Shared constants, widths and helper functions for the FM quadrature demodulator.
package fqd_pkg;

	localparam int SmpW    = 21;   // intermediate sample / accumulator width
	localparam int ProdW   = 42;   // one I/Q cross product
	localparam int DotW    = 43;   // sum of two cross products
	localparam int CordW   = 45;   // CORDIC x/y datapath, covers gain and swap
	localparam int AngW    = 26;   // angle accumulator, Q24 units of pi
	localparam int StepW   = 4;    // CORDIC step index
	localparam int DecW    = 5;    // decimation register width
	localparam int PcmW    = 16;

	localparam logic signed [AngW-1:0] HalfPiQ24 = 26'sd8388608;
	localparam logic signed [PcmW-1:0] PcmMax    = 16'sd32767;

	// Register map, word index
	localparam logic RegIfDec    = 1'b0;
	localparam logic RegAudioDec = 1'b1;

	// Zero acts as one, anything above sixteen acts as sixteen.
	function automatic logic [DecW-1:0] eff_dec(input logic [DecW-1:0] d);
		logic [DecW-1:0] r;
		begin
			if (d == '0)
				r = 5'd1;
			else if (d > 5'd16)
				r = 5'd16;
			else
				r = d;
			return r;
		end
	endfunction

	// atan(2^-k) in Q24 units of pi, rounded to nearest
	function automatic logic signed [AngW-1:0] atan_q24(input logic [StepW-1:0] k);
		logic signed [AngW-1:0] r;
		begin
			case (k)
				4'd0:    r = 26'sd4194304;
				4'd1:    r = 26'sd2476042;
				4'd2:    r = 26'sd1308273;
				4'd3:    r = 26'sd664100;
				4'd4:    r = 26'sd333339;
				4'd5:    r = 26'sd166832;
				4'd6:    r = 26'sd83436;
				4'd7:    r = 26'sd41721;
				4'd8:    r = 26'sd20861;
				4'd9:    r = 26'sd10430;
				4'd10:   r = 26'sd5215;
				4'd11:   r = 26'sd2608;
				4'd12:   r = 26'sd1304;
				4'd13:   r = 26'sd652;
				4'd14:   r = 26'sd326;
				4'd15:   r = 26'sd163;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/core/fm_quadrature_demodulator_top.sv */
// Top level of the FM quadrature demodulator: sequencer, shared multiplier, register port.
//
// Input stream (s_*): one raw I/Q byte pair per transaction. The pair is turned by
// a repeating fs/4 rotation, offset to signed and summed over if_decimation items.
// An item that does not close an intermediate sample is only summed in.
// An item that closes an intermediate sample runs the sequencer: cross products on
// one 21x21 multiplier, a check, CORDIC on one shift/add unit (skipped when the
// imaginary part is zero), averaging and, every audio_decimation-th time, the
// bit-serial divider and the output state, which waits while the old sample is
// not taken. s_tready is low for all of that.
// Output stream (m_*): one signed PCM sample per transaction, held in an output
// register. A new input item is accepted while that sample still waits; when the
// next sample is ready and the old one is not taken, the sequencer waits.
// APB port: register 0 if_decimation at 0x0, register 1 audio_decimation at 0x4.
// Write only while idle. Reset returns both to 6 and 4 and clears the sequencer, counters and accumulators.
module fm_quadrature_demodulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [7:0] i_byte, [15:8] q_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [15:0] pcm_sample
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_CHK, ST_CORD, ST_ANG, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	logic [fqd_pkg::DecW-1:0] if_dec_q, aud_dec_q;
	logic [1:0]               rot_q;
	logic [3:0]               if_cnt_q, aud_cnt_q;
	logic signed [fqd_pkg::SmpW-1:0] i_acc_q, q_acc_q, prev_i_q, prev_q_q;
	logic signed [fqd_pkg::SmpW-1:0] cur_i_q, cur_q_q, aud_acc_q, div_num_q;
	logic signed [fqd_pkg::ProdW-1:0] prod_q;
	logic signed [fqd_pkg::DotW-1:0]  re_q, im_q;
	logic [2:0]               mcnt_q;
	logic signed [fqd_pkg::PcmW-1:0]  ang_q;
	logic [fqd_pkg::DecW-1:0] div_den_q;
	logic                     cord_start_q, div_start_q;
	logic                     m_tvalid_q;
	logic [15:0]              m_tdata_q;

	logic [7:0]  i_byte, q_byte, ri, rq;
	logic signed [8:0] i_off, q_off;
	logic signed [fqd_pkg::SmpW-1:0] i_next, q_next, op_a, op_b, aud_next;
	logic signed [fqd_pkg::DotW-1:0] prod_x, im_abs;
	logic        cord_done, div_done;
	logic signed [fqd_pkg::AngW-1:0] cord_z;
	logic signed [fqd_pkg::SmpW-1:0] div_quot;
	logic [16:0] z_q9;
	logic signed [fqd_pkg::PcmW-1:0] ang_mag;
	logic        wr_en, accept;

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite & pready;
	assign prdata   = (paddr[2] == fqd_pkg::RegAudioDec) ? {27'd0, aud_dec_q}
	                                                     : {27'd0, if_dec_q};
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign i_byte = s_tdata[7:0];
	assign q_byte = s_tdata[15:8];

	// fs/4 rotation, complement is 255-x
	always_comb begin
		case (rot_q)
			2'd0:    begin ri = i_byte;  rq = q_byte;  end
			2'd1:    begin ri = ~q_byte; rq = i_byte;  end
			2'd2:    begin ri = ~i_byte; rq = ~q_byte; end
			default: begin ri = q_byte;  rq = ~i_byte; end
		endcase
	end

	assign i_off  = $signed({1'b0, ri}) - 9'sd127;
	assign q_off  = $signed({1'b0, rq}) - 9'sd127;
	assign i_next = i_acc_q + $signed({{4{i_off[8]}}, i_off, 8'h00});
	assign q_next = q_acc_q + $signed({{4{q_off[8]}}, q_off, 8'h00});

	// product order: ci*pi, cq*pq, cq*pi, ci*pq
	assign op_a   = (mcnt_q == 3'd0 || mcnt_q == 3'd3) ? cur_i_q : cur_q_q;
	assign op_b   = mcnt_q[0] ? prev_q_q : prev_i_q;
	assign prod_x = fqd_pkg::DotW'(prod_q);
	assign im_abs = im_q[fqd_pkg::DotW-1] ? -im_q : im_q;

	// z>>9 clamped to 0..32767
	assign z_q9    = cord_z[fqd_pkg::AngW-1:9];
	assign ang_mag = cord_z[fqd_pkg::AngW-1] ? '0 :
	                 (z_q9 > 17'd32767) ? fqd_pkg::PcmMax : $signed(z_q9[15:0]);
	assign aud_next = aud_acc_q + fqd_pkg::SmpW'(ang_q);

	fqd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start_q),
		.re     (re_q),
		.im_mag (im_abs),
		.done   (cord_done),
		.angle  (cord_z)
	);

	fqd_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_dec_q  <= 5'd6;
			aud_dec_q <= 5'd4;
		end else if (wr_en) begin
			case (paddr[2])
				fqd_pkg::RegIfDec:    if_dec_q  <= pwdata[4:0];
				fqd_pkg::RegAudioDec: aud_dec_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rot_q        <= '0;
			if_cnt_q     <= '0;
			aud_cnt_q    <= '0;
			i_acc_q      <= '0;
			q_acc_q      <= '0;
			prev_i_q     <= '0;
			prev_q_q     <= '0;
			aud_acc_q    <= '0;
			mcnt_q       <= '0;
			cord_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			cord_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			// in ST_OUT the output register is handled by the state itself
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rot_q <= rot_q + 1'b1;
						if ({1'b0, if_cnt_q} + 5'd1 < fqd_pkg::eff_dec(if_dec_q)) begin
							i_acc_q  <= i_next;
							q_acc_q  <= q_next;
							if_cnt_q <= if_cnt_q + 1'b1;
						end else begin
							cur_i_q  <= i_next;
							cur_q_q  <= q_next;
							i_acc_q  <= '0;
							q_acc_q  <= '0;
							if_cnt_q <= '0;
							re_q     <= '0;
							im_q     <= '0;
							mcnt_q   <= '0;
							state_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mcnt_q != 3'd4)
						prod_q <= op_a * op_b;
					case (mcnt_q)
						3'd1, 3'd2: re_q <= re_q + prod_x;
						3'd3:       im_q <= im_q + prod_x;
						3'd4:       im_q <= im_q - prod_x;
						default: ;
					endcase
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'd4) begin
						prev_i_q <= cur_i_q;
						prev_q_q <= cur_q_q;
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (im_q == '0) begin
						ang_q   <= re_q[fqd_pkg::DotW-1] ? fqd_pkg::PcmMax : '0;
						state_q <= ST_ANG;
					end else begin
						cord_start_q <= 1'b1;
						state_q      <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						ang_q   <= im_q[fqd_pkg::DotW-1] ? -ang_mag : ang_mag;
						state_q <= ST_ANG;
					end
				end
				ST_ANG: begin
					if ({1'b0, aud_cnt_q} + 5'd1 < fqd_pkg::eff_dec(aud_dec_q)) begin
						aud_acc_q <= aud_next;
						aud_cnt_q <= aud_cnt_q + 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						div_num_q   <= aud_next;
						div_den_q   <= fqd_pkg::eff_dec(aud_dec_q);
						div_start_q <= 1'b1;
						aud_acc_q   <= '0;
						aud_cnt_q   <= '0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= div_quot[15:0];
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cord_start_q && !div_start_q)
		else $error("input accepted while an arithmetic unit is being started");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("output sample raised outside the output state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished while sequencer not waiting for it");

	a_cord_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == ST_CORD)
		else $error("CORDIC finished while sequencer not waiting for it");

endmodule

/* rtl/core/fqd_cordic.sv */
// Iterative vectoring CORDIC: one shift/add step per cycle, angle in Q24 units of pi.
module fqd_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [fqd_pkg::DotW-1:0]      re,
	input  logic signed [fqd_pkg::DotW-1:0]      im_mag,
	output logic                                 done,
	output logic signed [fqd_pkg::AngW-1:0]      angle
);

	logic                               busy_q;
	logic [fqd_pkg::StepW-1:0]          k_q;
	logic signed [fqd_pkg::CordW-1:0]   x_q, y_q;
	logic signed [fqd_pkg::AngW-1:0]    z_q;
	logic signed [fqd_pkg::CordW-1:0]   re_x, im_x, dx, dy;
	logic signed [fqd_pkg::AngW-1:0]    t;

	assign re_x  = fqd_pkg::CordW'(re);
	assign im_x  = fqd_pkg::CordW'(im_mag);
	assign dx    = y_q >>> k_q;
	assign dy    = x_q >>> k_q;
	assign t     = fqd_pkg::atan_q24(k_q);
	assign angle = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			k_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				// left half plane: pre-rotate by -pi/2
				if (re[fqd_pkg::DotW-1]) begin
					x_q <= im_x;
					y_q <= -re_x;
					z_q <= fqd_pkg::HalfPiQ24;
				end else begin
					x_q <= re_x;
					y_q <= im_x;
					z_q <= '0;
				end
			end else if (busy_q) begin
				if (!y_q[fqd_pkg::CordW-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + t;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - t;
				end
				k_q <= k_q + 1'b1;
				if (k_q == '1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/fqd_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module fqd_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [fqd_pkg::SmpW-1:0]      num,
	input  logic [fqd_pkg::DecW-1:0]             den,
	output logic                                 done,
	output logic signed [fqd_pkg::SmpW-1:0]      quot
);

	logic                          busy_q;
	logic                          neg_q;
	logic [4:0]                    cnt_q;
	logic [fqd_pkg::SmpW-1:0]      mag_q;
	logic [fqd_pkg::DecW-1:0]      den_q;
	logic [fqd_pkg::DecW-1:0]      rem_q;
	logic [fqd_pkg::DecW:0]        trial;
	logic                          take;

	assign trial = {rem_q, mag_q[fqd_pkg::SmpW-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= num[fqd_pkg::SmpW-1];
				mag_q  <= num[fqd_pkg::SmpW-1] ? -num : num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				// remainder stays below den, so it fits DecW bits
				rem_q <= take ? fqd_pkg::DecW'(trial - {1'b0, den_q})
				              : trial[fqd_pkg::DecW-1:0];
				mag_q <= {mag_q[fqd_pkg::SmpW-2:0], take};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(fqd_pkg::SmpW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
			if (busy_q && !start && cnt_q == 5'(fqd_pkg::SmpW - 1))
				quot <= neg_q ? -$signed({mag_q[fqd_pkg::SmpW-2:0], take})
				              : $signed({mag_q[fqd_pkg::SmpW-2:0], take});
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the FM quadrature demodulator: stream driver, monitor, predictor.
module tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;     // [7:0] i_byte, [15:8] q_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // [15:0] pcm_sample
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fm_quadrature_demodulator_top DUT (.*);

	localparam logic [2:0] AddrIfDec    = 3'd0;
	localparam logic [2:0] AddrAudioDec = 3'd4;
	localparam int         CycleLimit   = 600000;

	// predictor state
	logic [4:0]  if_dec_reg, audio_dec_reg;
	logic [1:0]  rot_phase;
	int unsigned if_cnt, audio_cnt;
	longint      i_acc, q_acc, prev_i, prev_q, audio_sum;

	logic [15:0] pair_q[$];
	logic [15:0] pcm_q[$];
	int          errors;
	int          cycles;
	bit          burst_mode;
	bit          hold_req;
	int          hold_left;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int unsigned dec_of(input logic [4:0] d);
		if (d == 0) return 1;
		if (d > 16) return 16;
		return d;
	endfunction

	function automatic longint atan_step(input int k);
		case (k)
			0: return 4194304;  1: return 2476042;  2: return 1308273;  3: return 664100;
			4: return 333339;   5: return 166832;   6: return 83436;    7: return 41721;
			8: return 20861;    9: return 10430;    10: return 5215;    11: return 2608;
			12: return 1304;    13: return 652;     14: return 326;     default: return 163;
		endcase
	endfunction

	// angle of (re, im) in Q15 units of pi
	function automatic int angle_q15(input longint re, input longint im);
		longint x, y, z, t, dx, dy, r;
		z = 0;
		if (im == 0) return (re < 0) ? 32767 : 0;
		x = re;
		y = (im < 0) ? -im : im;
		if (x < 0) begin
			t = x; x = y; y = -t;
			z = 8388608;
		end
		for (int k = 0; k < 16; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(k);
			end else begin
				x -= dx; y += dy; z -= atan_step(k);
			end
		end
		r = (z < 0) ? 0 : (z >>> 9);
		if (r > 32767) r = 32767;
		return int'((im < 0) ? -r : r);
	endfunction

	task automatic predict_pcm(input logic [7:0] ib, input logic [7:0] qb);
		int ri, rq, ang, d;
		int pcm;
		case (rot_phase)
			2'd0: begin ri = ib; rq = qb; end
			2'd1: begin ri = 255 - qb; rq = ib; end
			2'd2: begin ri = 255 - ib; rq = 255 - qb; end
			default: begin ri = qb; rq = 255 - ib; end
		endcase
		rot_phase = rot_phase + 2'd1;
		i_acc += (ri - 127) * 256;
		q_acc += (rq - 127) * 256;
		if (if_cnt + 1 < dec_of(if_dec_reg)) begin
			if_cnt++;
			return;
		end
		if_cnt = 0;
		ang = angle_q15(i_acc * prev_i + q_acc * prev_q, q_acc * prev_i - i_acc * prev_q);
		prev_i = i_acc;
		prev_q = q_acc;
		i_acc = 0;
		q_acc = 0;
		audio_sum += ang;
		d = dec_of(audio_dec_reg);
		if (audio_cnt + 1 < d) begin
			audio_cnt++;
			return;
		end
		audio_cnt = 0;
		pcm = int'(audio_sum) / d;
		pcm_q.push_back(pcm[15:0]);
		audio_sum = 0;
	endtask

	// input driver
	bit sent;
	always @(posedge clk) begin
		sent <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			predict_pcm(s_tdata[7:0], s_tdata[15:8]);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || sent) begin
			if (pair_q.size() > 0 && (burst_mode || $urandom_range(99) >= 26)) begin
				s_tdata  <= pair_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= burst_mode || $urandom_range(99) >= 26;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pcm_q.size() == 0) begin
				$display("%0t: unexpected pcm_sample %0d", $time, $signed(m_tdata));
				errors++;
			end else begin
				if (pcm_q[0] !== m_tdata) begin
					$display("%0t: pcm_sample mismatch: expected %0d, actual %0d",
						$time, $signed(pcm_q[0]), $signed(m_tdata));
					errors++;
				end
				void'(pcm_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [4:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= addr; pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == AddrIfDec) if_dec_reg = val;
		else audio_dec_reg = val;
	endtask

	task automatic drain;
		wait (pair_q.size() == 0 && !s_tvalid && pcm_q.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_random(input int n);
		logic [7:0] ib, qb;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				ib = $urandom_range(1) ? 8'hFF : 8'h00;
				qb = $urandom_range(1) ? 8'hFF : 8'h00;
			end else begin
				ib = $urandom_range(255);
				qb = $urandom_range(255);
			end
			pair_q.push_back({qb, ib});
		end
	endtask

	initial begin
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; cycles = 0; burst_mode = 1'b0; hold_req = 1'b0; hold_left = 0;
		if_dec_reg = 5'd6; audio_dec_reg = 5'd4;
		rot_phase = '0; if_cnt = 0; audio_cnt = 0;
		i_acc = 0; q_acc = 0; prev_i = 0; prev_q = 0; audio_sum = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: flat input (all-zero vectors), corners, then a spinning carrier
		repeat (6) pair_q.push_back({8'd127, 8'd127});
		pair_q.push_back({8'h00, 8'h00});
		pair_q.push_back({8'hFF, 8'hFF});
		pair_q.push_back({8'h00, 8'hFF});
		pair_q.push_back({8'hFF, 8'h00});
		pair_q.push_back({8'hAA, 8'h55});
		pair_q.push_back({8'h55, 8'hAA});
		repeat (13) pair_q.push_back({8'd127, 8'd255});
		drain();

		reg_write(AddrIfDec, 5'd1);
		reg_write(AddrAudioDec, 5'd1);
		hold_req = 1'b1;
		load_random(150);
		drain();

		reg_write(AddrIfDec, 5'd16);
		reg_write(AddrAudioDec, 5'd16);
		load_random(40);
		drain();

		// lowered with a partial count pending
		burst_mode = 1'b1;
		reg_write(AddrIfDec, 5'd3);
		reg_write(AddrAudioDec, 5'd2);
		load_random(100);
		drain();
		burst_mode = 1'b0;

		reg_write(AddrIfDec, 5'd0);
		reg_write(AddrAudioDec, 5'd0);
		load_random(60);
		drain();

		reg_write(AddrIfDec, 5'd31);
		reg_write(AddrAudioDec, 5'd17);
		load_random(40);
		drain();

		reg_write(AddrIfDec, 5'd2);
		reg_write(AddrAudioDec, 5'd5);
		load_random(60);
		drain();

		reg_write(AddrIfDec, 5'd5);
		reg_write(AddrAudioDec, 5'd1);
		load_random(60);
		drain();

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fqd_pkg.sv
rtl/core/fqd_cordic.sv
rtl/core/fqd_divider.sv
rtl/core/fm_quadrature_demodulator_top.sv
tb/tb.sv
